// ===== rtl/core/plst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package plst_pkg;

	// List geometry
	localparam int DEPTH = 32;
	localparam int WIDTH = 32;

	// Fixed field widths of the channels
	localparam int OP_W    = 2;
	localparam int DATA_W  = 32;
	localparam int POS_W   = 6;
	localparam int STAT_W  = 3;

	// Count holds 0..DEPTH, a cell index holds 0..DEPTH-1
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Compare width that holds a position, a count and both plus one
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic signed [WIDTH-1:0]  word_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CMP_W-1:0]         cmp_t;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_DELETE   = 2'd1,
		OP_SEARCH   = 2'd2,
		OP_TRAVERSE = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ELEMENT   = 3'd4,
		ST_BAD_POS   = 3'd5,
		ST_FULL      = 3'd6,
		ST_EMPTY     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_TRAV = 1'b1
	} fsm_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		cell_op_t op;
		cmp_t     pos;
		cmp_t     count;
		word_t    value;
	} cell_ctrl_t;

	// Keep an input value at the stored word width
	function automatic word_t to_word(input data_t v);
		return word_t'(v);
	endfunction

	// Widen a stored word to the element field
	function automatic data_t to_data(input word_t w);
		return data_t'(w);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/plst_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Operation request channel
interface plst_req_if;
	logic                             valid;
	logic                             ready;
	logic [plst_pkg::OP_W-1:0]        op;
	logic signed [plst_pkg::DATA_W-1:0] value;
	logic [plst_pkg::POS_W-1:0]       position;

	modport source (output valid, output op, output value, output position, input ready);
	modport sink (input valid, input op, input value, input position, output ready);
endinterface

// Result channel
interface plst_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [plst_pkg::STAT_W-1:0]      status;
	logic signed [plst_pkg::DATA_W-1:0] element;
	logic [plst_pkg::POS_W-1:0]       where;
	logic [plst_pkg::POS_W-1:0]       count_now;
	logic                             last;

	modport source (output valid, output status, output element, output where,
		output count_now, output last, input ready);
	modport sink (input valid, input status, input element, input where,
		input count_now, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/plst_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module plst_cell (
	input  wire logic                        clk,
	input  wire logic [plst_pkg::IDX_W-1:0]  idx,
	input  wire plst_pkg::cell_ctrl_t        ctrl,
	input  wire plst_pkg::word_t             left_word,
	input  wire plst_pkg::word_t             right_word,
	input  wire plst_pkg::word_t             head_word,
	input  wire logic                        hit_in,
	output plst_pkg::word_t                  word,
	output logic                             hit_out,
	output logic                             first
);

	plst_pkg::word_t word_q;
	plst_pkg::word_t word_d;
	plst_pkg::cmp_t  idx1;
	logic            my_hit;

	// 1-based place of this cell
	assign idx1 = plst_pkg::CMP_W'(idx) + plst_pkg::CMP_W'(1);

	// Select the next word: hold, take the new value, shift from a neighbor, or wrap the head around
	always_comb begin
		word_d = word_q;
		case (ctrl.op)
			plst_pkg::CELL_INSERT: begin
				if (idx1 == ctrl.pos) begin
					word_d = ctrl.value;
				end else if (idx1 > ctrl.pos) begin
					word_d = left_word;
				end
			end
			plst_pkg::CELL_DELETE: begin
				if (idx1 >= ctrl.pos) begin
					word_d = right_word;
				end
			end
			plst_pkg::CELL_ROTATE: begin
				if (idx1 < ctrl.count) begin
					word_d = right_word;
				end else if (idx1 == ctrl.count) begin
					word_d = head_word;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	// Compare against the search value; pass the hit chain on
	assign my_hit  = (idx1 <= ctrl.count) && (word_q == ctrl.value);
	assign hit_out = hit_in | my_hit;
	assign first   = my_hit & ~hit_in;
	assign word    = word_q;

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                                      | Handshake
// req     | in  | op, value, position                          | valid/ready
// rsp     | out | status, element, where, count_now, last      | valid/ready
//
// Insert, delete and search complete on acceptance: every cell of the chain shifts
// or compares in parallel, and the result lands in the output register.
// A traverse first starts without a result, then gives one head entry per cycle while rsp
// is not stalled, as the chain rotates by one place; after count steps the order is restored.
// A stalled rsp holds the output register and pauses the rotation; reset clears
// the count and the control state, the entry cells keep no reset.

module positional_list_store (
	input wire logic   clk,
	input wire logic   arst_n,
	plst_req_if.sink   req,
	plst_rsp_if.source rsp
);

	plst_pkg::fsm_t                 state_q;
	plst_pkg::fsm_t                 state_d;
	logic [plst_pkg::CNT_W-1:0]     count_q;
	logic [plst_pkg::CNT_W-1:0]     count_d;
	logic [plst_pkg::IDX_W-1:0]     trav_idx_q;

	logic                           out_valid_q;
	logic [plst_pkg::STAT_W-1:0]    status_q;
	plst_pkg::data_t                element_q;
	logic [plst_pkg::POS_W-1:0]     where_q;
	logic [plst_pkg::POS_W-1:0]     count_now_q;
	logic                           last_q;

	logic                           slot_free;
	logic                           accept;
	logic                           emit;
	logic                           trav_start;
	logic                           load_out;
	logic                           trav_last;
	plst_pkg::op_t                  op;
	plst_pkg::cmp_t                 pos_c;
	plst_pkg::cmp_t                 cnt_c;
	logic                           full;
	logic                           ins_ok;
	logic                           del_ok;

	plst_pkg::cell_ctrl_t           ctrl;
	plst_pkg::word_t                words [plst_pkg::DEPTH];
	logic [plst_pkg::DEPTH:0]       hit;
	logic [plst_pkg::DEPTH-1:0]     first;
	logic [plst_pkg::POS_W-1:0]     hit_where;

	plst_pkg::status_t              res_status;
	plst_pkg::data_t                res_element;
	logic [plst_pkg::POS_W-1:0]     res_where;
	logic                           res_last;

	// Handshake
	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == plst_pkg::FSM_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign emit      = (state_q == plst_pkg::FSM_TRAV) && slot_free;

	// Decode the request
	assign op     = plst_pkg::op_t'(req.op);
	assign pos_c  = plst_pkg::CMP_W'(req.position);
	assign cnt_c  = plst_pkg::CMP_W'(count_q);
	assign full   = cnt_c >= plst_pkg::CMP_W'(plst_pkg::DEPTH);
	assign ins_ok = !full && (pos_c != '0) && (pos_c <= cnt_c + plst_pkg::CMP_W'(1));
	assign del_ok = (pos_c != '0) && (pos_c <= cnt_c);
	assign trav_last = (plst_pkg::CMP_W'(trav_idx_q) + plst_pkg::CMP_W'(1)) == cnt_c;

	// A traverse of a non-empty list starts without a result of its own
	assign trav_start = accept && (op == plst_pkg::OP_TRAVERSE) && (count_q != '0);
	assign load_out   = (accept && !trav_start) || emit;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			plst_pkg::FSM_IDLE: begin
				if (trav_start) begin
					state_d = plst_pkg::FSM_TRAV;
				end
			end
			plst_pkg::FSM_TRAV: begin
				if (emit && trav_last) begin
					state_d = plst_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = plst_pkg::FSM_IDLE;
			end
		endcase
	end

	// Cell control, count update and result fields
	always_comb begin
		ctrl.op     = plst_pkg::CELL_HOLD;
		ctrl.pos    = pos_c;
		ctrl.count  = cnt_c;
		ctrl.value  = plst_pkg::to_word(req.value);
		count_d     = count_q;
		res_status  = plst_pkg::ST_EMPTY;
		res_element = '0;
		res_where   = '0;
		res_last    = 1'b1;
		case (state_q)
			plst_pkg::FSM_IDLE: begin
				case (op)
					plst_pkg::OP_INSERT: begin
						if (full) begin
							res_status = plst_pkg::ST_FULL;
						end else if (!ins_ok) begin
							res_status = plst_pkg::ST_BAD_POS;
						end else begin
							res_status = plst_pkg::ST_INSERTED;
							count_d    = count_q + plst_pkg::CNT_W'(1);
							if (accept) begin
								ctrl.op = plst_pkg::CELL_INSERT;
							end
						end
					end
					plst_pkg::OP_DELETE: begin
						if (!del_ok) begin
							res_status = plst_pkg::ST_BAD_POS;
						end else begin
							res_status = plst_pkg::ST_DELETED;
							count_d    = count_q - plst_pkg::CNT_W'(1);
							if (accept) begin
								ctrl.op = plst_pkg::CELL_DELETE;
							end
						end
					end
					plst_pkg::OP_SEARCH: begin
						if (hit[plst_pkg::DEPTH]) begin
							res_status = plst_pkg::ST_FOUND;
							res_where  = hit_where;
						end else begin
							res_status = plst_pkg::ST_NOT_FOUND;
						end
					end
					plst_pkg::OP_TRAVERSE: begin
						res_status = plst_pkg::ST_EMPTY;
					end
					default: begin
						res_status = plst_pkg::ST_EMPTY;
					end
				endcase
			end
			plst_pkg::FSM_TRAV: begin
				res_status  = plst_pkg::ST_ELEMENT;
				res_element = plst_pkg::to_data(words[0]);
				res_where   = plst_pkg::POS_W'(plst_pkg::CMP_W'(trav_idx_q) + plst_pkg::CMP_W'(1));
				res_last    = trav_last;
				if (emit) begin
					ctrl.op = plst_pkg::CELL_ROTATE;
				end
			end
			default: begin
				res_status = plst_pkg::ST_EMPTY;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plst_pkg::FSM_IDLE;
			count_q     <= '0;
			trav_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q    <= count_d;
				trav_idx_q <= '0;
			end else if (emit) begin
				trav_idx_q <= trav_idx_q + plst_pkg::IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q    <= res_status;
			element_q   <= res_element;
			where_q     <= res_where;
			count_now_q <= plst_pkg::POS_W'(count_d);
			last_q      <= res_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.element   = element_q;
	assign rsp.where     = where_q;
	assign rsp.count_now = count_now_q;
	assign rsp.last      = last_q;

	// Chain of entry cells
	assign hit[0] = 1'b0;

	for (genvar i = 0; i < plst_pkg::DEPTH; i++) begin : g_cell
		plst_pkg::word_t left_w;
		plst_pkg::word_t right_w;

		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = words[i-1];
		end

		if (i == plst_pkg::DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_body
			assign right_w = words[i+1];
		end

		plst_cell u_cell (
			.clk        (clk),
			.idx        (plst_pkg::IDX_W'(i)),
			.ctrl       (ctrl),
			.left_word  (left_w),
			.right_word (right_w),
			.head_word  (words[0]),
			.hit_in     (hit[i]),
			.word       (words[i]),
			.hit_out    (hit[i+1]),
			.first      (first[i])
		);
	end

	// Encode the first hit as a 1-based position
	always_comb begin
		hit_where = '0;
		for (int i = 0; i < plst_pkg::DEPTH; i++) begin
			if (first[i]) begin
				hit_where = hit_where | plst_pkg::POS_W'(i + 1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/plst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module plst_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [plst_pkg::STAT_W-1:0]   rsp_status,
	input wire logic [plst_pkg::DATA_W-1:0]   rsp_element,
	input wire logic [plst_pkg::POS_W-1:0]    rsp_where,
	input wire logic [plst_pkg::POS_W-1:0]    rsp_count_now,
	input wire logic                          rsp_last
);

	// Count never exceeds the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_count_now <= plst_pkg::POS_W'(plst_pkg::DEPTH)))
		else $error("count_now above list depth");

	// Every result other than a traverse element closes its transaction
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != plst_pkg::ST_ELEMENT) |-> rsp_last)
		else $error("non-element result without last");

	// Position and element are zero where they carry no meaning
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != plst_pkg::ST_ELEMENT && rsp_status != plst_pkg::ST_FOUND)
		|-> (rsp_where == '0 && rsp_element == '0))
		else $error("where or element nonzero on plain result");

	// Traverse elements carry a nonzero position, and last marks the one at the count
	a_elem_where: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == plst_pkg::ST_ELEMENT)
		|-> (rsp_where != '0 && (rsp_last == (rsp_where == rsp_count_now))))
		else $error("traverse position inconsistent with last");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
		&& $stable(rsp_element) && $stable(rsp_where) && $stable(rsp_last)))
		else $error("stalled result changed");

endmodule

bind positional_list_store plst_checker u_plst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_element   (rsp.element),
	.rsp_where     (rsp.where),
	.rsp_count_now (rsp.count_now),
	.rsp_last      (rsp.last)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import plst_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned MAX_REPORTS = 40;
	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// One operation on its way to the list, with its pacing
	typedef struct {
		op_t              op;
		data_t            value;
		logic [POS_W-1:0] position;
		int unsigned      gap;
		bit               wait_idle;
		bit               hold_rx;
		int unsigned      rx_max;
	} list_request_t;

	// One result the list should answer with
	typedef struct {
		status_t          status;
		data_t            element;
		logic [POS_W-1:0] where;
		logic [POS_W-1:0] count_now;
		logic             last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	plst_req_if req_ch();
	plst_rsp_if rsp_ch();

	positional_list_store DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	list_request_t request_queue[$];
	list_result_t  result_queue[$];
	word_t         shadow_list[$];
	data_t         value_pool[$];
	int            plan_count = 0;
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;

	bit            offering = 1'b0;
	bit            gap_loaded = 1'b0;
	int unsigned   gap_left = 0;
	int unsigned   rx_stall_max = 0;
	int unsigned   rx_stall_left = 0;
	int unsigned   rx_hold_left = 0;

	// Free-running clock
	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Queue one expected result; count_now is the list size after the operation
	function automatic void push_result(input status_t status, input data_t element,
			input int where, input logic last);
		list_result_t res;
		res.status = status;
		res.element = element;
		res.where = where[POS_W-1:0];
		res.count_now = POS_W'(shadow_list.size());
		res.last = last;
		result_queue.push_back(res);
	endfunction

	// Apply one operation to the shadow list and queue what the block must return
	task automatic apply_list_op(input op_t op, input data_t value,
			input logic [POS_W-1:0] position);
		int p;
		int hit;
		int i;
		int n;
		word_t w;
		p = int'(position);
		w = word_t'(value);
		n = shadow_list.size();
		hit = 0;
		case (op)
			OP_INSERT: begin
				// full list wins over a bad position
				if (n >= DEPTH)
					push_result(ST_FULL, '0, 0, 1'b1);
				else if (p < 1 || p > n + 1)
					push_result(ST_BAD_POS, '0, 0, 1'b1);
				else begin
					shadow_list.insert(p - 1, w);
					push_result(ST_INSERTED, '0, 0, 1'b1);
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > n)
					push_result(ST_BAD_POS, '0, 0, 1'b1);
				else begin
					shadow_list.delete(p - 1);
					push_result(ST_DELETED, '0, 0, 1'b1);
				end
			end
			OP_SEARCH: begin
				// first match wins among duplicates
				for (i = 0; i < n; i++)
					if (hit == 0 && shadow_list[i] == w)
						hit = i + 1;
				if (hit != 0)
					push_result(ST_FOUND, '0, hit, 1'b1);
				else
					push_result(ST_NOT_FOUND, '0, 0, 1'b1);
			end
			default: begin
				if (n == 0)
					push_result(ST_EMPTY, '0, 0, 1'b1);
				else
					for (i = 0; i < n; i++)
						push_result(ST_ELEMENT, data_t'(shadow_list[i]), i + 1,
							(i + 1 == n) ? 1'b1 : 1'b0);
			end
		endcase
	endtask

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Monitor: check each result transaction, then predict from each request transaction
	always @(posedge clk) begin
		list_result_t want;
		list_request_t taken;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rx_stall_left = $urandom_range(0, rx_stall_max);
			if (result_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result with none expected, expected none, actual status %0d where %0d",
						$time, rsp_ch.status, rsp_ch.where);
			end else begin
				want = result_queue.pop_front();
				check_field("status", DATA_W'(want.status), DATA_W'(rsp_ch.status));
				check_field("element", want.element, rsp_ch.element);
				check_field("where", DATA_W'(want.where), DATA_W'(rsp_ch.where));
				check_field("count_now", DATA_W'(want.count_now), DATA_W'(rsp_ch.count_now));
				check_field("last", DATA_W'(want.last), DATA_W'(rsp_ch.last));
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			taken = request_queue.pop_front();
			rx_stall_max = taken.rx_max;
			if (taken.hold_rx)
				rx_hold_left = HOLD_CYCLES;
			apply_list_op(taken.op, taken.value, taken.position);
			offering = 1'b0;
		end
	end

	// Driver: offer the head request after its gap (and, if marked, once no result is pending), holding valid until taken
	always @(negedge clk) begin
		if (arst_n && !offering) begin
			if (request_queue.size() != 0 && !gap_loaded) begin
				gap_left = request_queue[0].gap;
				gap_loaded = 1'b1;
			end
			if (request_queue.size() != 0 && gap_left == 0
					&& (!request_queue[0].wait_idle || result_queue.size() == 0)) begin
				req_ch.valid <= 1'b1;
				req_ch.op <= request_queue[0].op;
				req_ch.value <= request_queue[0].value;
				req_ch.position <= request_queue[0].position;
				offering = 1'b1;
				gap_loaded = 1'b0;
			end else begin
				req_ch.valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end
		end
	end

	// Receiver: long hold-off first, then per-result stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_stall_left != 0) begin
				rx_stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Queue a request and track the planned list size for later positions
	task automatic plan_op(input op_t op, input data_t value, input int position,
			input int unsigned gap, input bit wait_idle, input bit hold_rx,
			input int unsigned rx_max);
		list_request_t item;
		item.op = op;
		item.value = value;
		item.position = position[POS_W-1:0];
		item.gap = gap;
		item.wait_idle = wait_idle;
		item.hold_rx = hold_rx;
		item.rx_max = rx_max;
		request_queue.push_back(item);
		if (op == OP_INSERT && plan_count < DEPTH && position >= 1
				&& position <= plan_count + 1) begin
			plan_count++;
			value_pool.push_back(value);
		end else if (op == OP_DELETE && position >= 1 && position <= plan_count) begin
			plan_count--;
		end
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return DATA_MAX;
			1: return DATA_MIN;
			2, 3, 4: return data_t'(int'($urandom_range(0, 15)) - 8);
			default: return data_t'($urandom);
		endcase
	endfunction

	// Random stretch that either grows the list toward full or shrinks it toward empty
	task automatic plan_segment(input int n, input bit filling, input int unsigned tx_max,
			input int unsigned rx_max, input bit hold_first);
		int k;
		int r;
		int pos;
		int ins_cut;
		int del_cut;
		op_t op;
		data_t value;
		ins_cut = filling ? 65 : 10;
		del_cut = filling ? 75 : 70;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < ins_cut)
				op = OP_INSERT;
			else if (r < del_cut)
				op = OP_DELETE;
			else if (r < 92)
				op = OP_SEARCH;
			else
				op = OP_TRAVERSE;
			// mostly legal positions, some noise over the whole field
			pos = $urandom_range(0, 63);
			if ($urandom_range(0, 99) < 85) begin
				if (op == OP_INSERT)
					pos = $urandom_range(1, plan_count + 1);
				else if (op == OP_DELETE && plan_count > 0)
					pos = $urandom_range(1, plan_count);
			end
			value = pick_value();
			if (op == OP_SEARCH && value_pool.size() != 0 && $urandom_range(0, 9) < 6)
				value = value_pool[$urandom_range(0, value_pool.size() - 1)];
			plan_op(op, value, pos, (tx_max != 0) ? $urandom_range(0, tx_max) : 0,
				k == 0, hold_first && k == 0, rx_max);
		end
	endtask

	// Stimulus: reset, directed cases, random stretches, then drain and report
	initial begin
		req_ch.valid = 1'b0;
		req_ch.op = OP_INSERT;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;

		// empty list corners
		plan_op(OP_TRAVERSE, '0, 0, 0, 1'b0, 1'b0, 5);
		plan_op(OP_DELETE, '0, 1, 2, 1'b0, 1'b0, 5);
		plan_op(OP_SEARCH, '0, 0, 0, 1'b0, 1'b0, 5);
		plan_op(OP_INSERT, 32'sd5, 0, 1, 1'b0, 1'b0, 5);
		plan_op(OP_INSERT, 32'sd5, 2, 0, 1'b0, 1'b0, 5);
		// build -1, 0, max, min through append, head and middle inserts
		plan_op(OP_INSERT, DATA_MAX, 1, 0, 1'b0, 1'b0, 5);
		plan_op(OP_INSERT, DATA_MIN, 2, 3, 1'b0, 1'b0, 5);
		plan_op(OP_INSERT, -32'sd1, 1, 0, 1'b0, 1'b0, 5);
		plan_op(OP_INSERT, '0, 2, 0, 1'b0, 1'b0, 5);
		plan_op(OP_SEARCH, DATA_MIN, 0, 0, 1'b0, 1'b0, 5);
		plan_op(OP_SEARCH, -32'sd1, 0, 4, 1'b0, 1'b0, 5);
		plan_op(OP_SEARCH, 32'sd12345, 0, 0, 1'b0, 1'b0, 5);
		plan_op(OP_TRAVERSE, '0, 0, 0, 1'b0, 1'b0, 5);
		// bad delete positions: far out, one past the end, zero; then tail and head deletes and a bad insert
		plan_op(OP_DELETE, '0, 63, 0, 1'b0, 1'b0, 5);
		plan_op(OP_DELETE, '0, 5, 1, 1'b0, 1'b0, 5);
		plan_op(OP_DELETE, '0, 0, 0, 1'b0, 1'b0, 5);
		plan_op(OP_DELETE, '0, 4, 0, 1'b0, 1'b0, 5);
		plan_op(OP_DELETE, '0, 1, 2, 1'b0, 1'b0, 5);
		plan_op(OP_INSERT, 32'sd7, 63, 0, 1'b0, 1'b0, 5);
		// duplicate values: search returns the first
		plan_op(OP_INSERT, '0, 1, 0, 1'b0, 1'b0, 5);
		plan_op(OP_SEARCH, '0, 0, 0, 1'b0, 1'b0, 5);
		plan_op(OP_TRAVERSE, '0, 0, 0, 1'b0, 1'b0, 5);

		plan_segment(90, 1'b1, 17, 17, 1'b0);
		plan_segment(80, 1'b0, 0, 0, 1'b0);
		plan_segment(90, 1'b1, 0, 0, 1'b1);
		plan_segment(90, 1'b0, 3, 17, 1'b0);
		plan_segment(50, 1'b1, 17, 0, 1'b0);
		plan_segment(50, 1'b0, 0, 17, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || result_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
